/* design/bfsp_pkg.sv */
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants for the shortest path engine: default sizes,
// command and register codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  // Default sizes
  localparam int unsigned NODES_DEF       = 32;
  localparam int unsigned WEIGHT_BITS_DEF = 32;

  // Field widths fixed by the interface
  localparam int unsigned NODE_FIELD_W = 5;
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  // Distance arithmetic
  localparam int unsigned DIST_W = 64;
  localparam logic signed [DIST_W-1:0] INF_DIST  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN  = 64'sh8000_0000_0000_0000;

  // Path output limit
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned PCNT_W      = $clog2(MAX_RESULTS);

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_EDGE    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0]      NODE_COUNT_RST = 6'd32;
  localparam logic [NODE_FIELD_W-1:0] START_NODE_RST = 5'd0;
  localparam logic signed [DATA_W-1:0] NO_EDGE_RST   = 32'sh7FFF_FFFF;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENDS,
    ST_INIT,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_EDGE_RD,
    ST_EDGE_ADD,
    ST_EDGE_CMP,
    ST_TGT_RD,
    ST_TGT_CHK,
    ST_PATH_RD,
    ST_PATH_OUT,
    ST_FAIL
  } bfsp_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_wr;
    logic latch;
    logic init_step;
    logic row_rd;
    logic row_ld;
    logic edge_rd;
    logic edge_add;
    logic edge_upd;
    logic adv;
    logic chk_begin;
    logic tgt_rd;
    logic path_begin;
    logic path_rd;
    logic path_emit;
    logic fail_emit;
  } bfsp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad_ends;
    logic last_col;
    logic last_row;
    logic last_round;
    logic no_rounds;
    logic chk_mode;
    logic relax;
    logic t_inf;
    logic path_more;
  } bfsp_status_t;

endpackage

/* design/bfsp_ctrl.sv */
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer for the shortest path engine: takes loads and runs, steps the
// datapath through initialization, relaxation rounds, the negative cycle
// check and the path walk.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  cmd_i,
  input  bfsp_pkg::bfsp_status_t status_i,
  output bfsp_pkg::bfsp_cmd_t    ctl_o,
  output logic                  busy
);
  import bfsp_pkg::*;

  bfsp_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_RUN) begin
            ctl_o.latch = 1'b1;
            state_d     = ST_ENDS;
          end else begin
            ctl_o.load_wr = 1'b1;
          end
        end
      end
      ST_ENDS: begin
        state_d = status_i.bad_ends ? ST_FAIL : ST_INIT;
      end
      ST_INIT: begin
        ctl_o.init_step = 1'b1;
        if (status_i.last_col) begin
          state_d = status_i.no_rounds ? ST_TGT_RD : ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        ctl_o.row_rd = 1'b1;
        state_d      = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        ctl_o.row_ld = 1'b1;
        state_d      = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        ctl_o.edge_rd = 1'b1;
        state_d       = ST_EDGE_ADD;
      end
      ST_EDGE_ADD: begin
        ctl_o.edge_add = 1'b1;
        state_d        = ST_EDGE_CMP;
      end
      ST_EDGE_CMP: begin
        // Any edge still relaxable in the check pass is a negative cycle
        if (status_i.chk_mode && status_i.relax) begin
          state_d = ST_FAIL;
        end else begin
          ctl_o.edge_upd = 1'b1;
          ctl_o.adv      = 1'b1;
          if (!status_i.last_col) begin
            state_d = ST_EDGE_RD;
          end else if (!status_i.last_row) begin
            state_d = ST_ROW_RD;
          end else if (status_i.chk_mode) begin
            ctl_o.path_begin = 1'b1;
            state_d          = ST_PATH_RD;
          end else if (!status_i.last_round) begin
            state_d = ST_ROW_RD;
          end else begin
            state_d = ST_TGT_RD;
          end
        end
      end
      ST_TGT_RD: begin
        ctl_o.tgt_rd = 1'b1;
        state_d      = ST_TGT_CHK;
      end
      ST_TGT_CHK: begin
        if (status_i.t_inf) begin
          state_d = ST_FAIL;
        end else begin
          ctl_o.chk_begin = 1'b1;
          state_d         = ST_ROW_RD;
        end
      end
      ST_PATH_RD: begin
        ctl_o.path_rd = 1'b1;
        state_d       = ST_PATH_OUT;
      end
      ST_PATH_OUT: begin
        ctl_o.path_emit = 1'b1;
        state_d         = status_i.path_more ? ST_PATH_RD : ST_IDLE;
      end
      ST_FAIL: begin
        ctl_o.fail_emit = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/bfsp_dpath.sv */
// ----------------------------------------------------------------------------
// bfsp_dpath
// Datapath of the shortest path engine: weight matrix, distance and
// predecessor memories, loop counters, saturating relax arithmetic and the
// registered result stage.
// ----------------------------------------------------------------------------
module bfsp_dpath #(
  parameter int unsigned NODES       = bfsp_pkg::NODES_DEF,
  parameter int unsigned WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bfsp_pkg::bfsp_cmd_t                     ctl_i,
  output bfsp_pkg::bfsp_status_t                  status_o,
  input  logic [bfsp_pkg::COUNT_W-1:0]           node_count_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]      start_node_i,
  input  logic signed [bfsp_pkg::DATA_W-1:0]     no_edge_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]      from_node_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]      to_node_i,
  input  logic signed [bfsp_pkg::DATA_W-1:0]     weight_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]      target_node_i,
  output logic [bfsp_pkg::NODE_FIELD_W-1:0]      path_node_o,
  output logic                                   found_o,
  output logic                                   last_o,
  output logic                                   result_valid_o
);
  import bfsp_pkg::*;

  localparam int unsigned NB = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned AW = $clog2(NODES * NODES);
  localparam int unsigned XW = 7;

  // Memories
  logic signed [WEIGHT_BITS-1:0] weight_mem [NODES*NODES];
  logic signed [DIST_W-1:0]      dist_mem   [NODES];
  logic [NB-1:0]                 pred_mem   [NODES];

  // Run parameters and loop counters
  logic [CW-1:0]           n_q;
  logic [NODE_FIELD_W-1:0] s_q, t_q;
  logic [NB-1:0]           u_q, v_q, r_q;
  logic                    chk_q;
  logic [NODES-1:0]        pvalid_q;
  logic [NB-1:0]           pv_q;
  logic [PCNT_W-1:0]       cnt_q;

  // Read data and arithmetic registers
  logic signed [WEIGHT_BITS-1:0] w_rd_q;
  logic signed [DIST_W-1:0]      dist_rd_q;
  logic [NB-1:0]                 pred_rd_q;
  logic signed [DIST_W-1:0]      du_q, cand_q;
  logic                          skip_q;

  // Result stage
  logic                    res_valid_q;
  logic [NODE_FIELD_W-1:0] res_node_q;
  logic                    res_found_q, res_last_q;

  logic [XW-1:0]                 nc_ext, n_eff;
  logic                          load_in_range;
  logic [AW-1:0]                 load_addr, edge_addr;
  logic signed [WEIGHT_BITS-1:0] load_w, no_edge_w;
  logic [NB-1:0]                 dist_raddr;
  logic                          dist_re;
  logic                          dist_we;
  logic [NB-1:0]                 dist_waddr;
  logic signed [DIST_W-1:0]      dist_wdata;
  logic signed [DIST_W-1:0]      w_ext;
  logic signed [DIST_W:0]        sum_full;
  logic signed [DIST_W-1:0]      sum_sat;
  logic                          last_col, last_row, relax, path_more, do_relax;

  // Clamp the node count into 1..NODES
  assign nc_ext = XW'(node_count_i);
  always_comb begin
    if (nc_ext == '0) begin
      n_eff = XW'(1);
    end else if (nc_ext > XW'(NODES)) begin
      n_eff = XW'(NODES);
    end else begin
      n_eff = nc_ext;
    end
  end

  // Load path into the weight matrix
  assign load_in_range = (XW'(from_node_i) < XW'(NODES)) && (XW'(to_node_i) < XW'(NODES));
  assign load_addr     = AW'(from_node_i) * AW'(NODES) + AW'(to_node_i);
  assign load_w        = WEIGHT_BITS'(weight_i);
  assign no_edge_w     = WEIGHT_BITS'(no_edge_i);
  assign edge_addr     = AW'(u_q) * AW'(NODES) + AW'(v_q);

  // Loop end flags
  assign last_col = ((CW'(v_q) + CW'(1)) == n_q);
  assign last_row = ((CW'(u_q) + CW'(1)) == n_q);

  // Saturating candidate distance
  assign w_ext    = DIST_W'(w_rd_q);
  assign sum_full = (DIST_W + 1)'(du_q) + (DIST_W + 1)'(w_ext);
  always_comb begin
    if (sum_full[DIST_W] != sum_full[DIST_W-1]) begin
      sum_sat = sum_full[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      sum_sat = sum_full[DIST_W-1:0];
    end
  end

  assign relax     = !skip_q && (dist_rd_q > cand_q);
  assign do_relax  = ctl_i.edge_upd && !chk_q && relax;
  assign path_more = pvalid_q[pv_q] && (cnt_q != PCNT_W'(MAX_RESULTS - 1));

  // Distance read address select
  always_comb begin
    dist_re    = ctl_i.row_rd || ctl_i.edge_rd || ctl_i.tgt_rd;
    dist_raddr = v_q;
    if (ctl_i.row_rd) begin
      dist_raddr = u_q;
    end else if (ctl_i.tgt_rd) begin
      dist_raddr = NB'(t_q);
    end
  end

  // Distance write: initialization sweep or relaxed edge
  always_comb begin
    dist_we    = ctl_i.init_step || do_relax;
    dist_waddr = v_q;
    if (ctl_i.init_step) begin
      dist_wdata = (XW'(v_q) == XW'(s_q)) ? '0 : INF_DIST;
    end else begin
      dist_wdata = cand_q;
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_wr && load_in_range) begin
      weight_mem[load_addr] <= load_w;
    end
    if (ctl_i.edge_rd) begin
      w_rd_q <= weight_mem[edge_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_re) begin
      dist_rd_q <= dist_mem[dist_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_relax) begin
      pred_mem[v_q] <= u_q;
    end
    if (ctl_i.path_rd) begin
      pred_rd_q <= pred_mem[pv_q];
    end
  end

  // Run parameters, loop counters, predecessor valid bits, path walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      s_q      <= '0;
      t_q      <= '0;
      u_q      <= '0;
      v_q      <= '0;
      r_q      <= '0;
      chk_q    <= 1'b0;
      pvalid_q <= '0;
      pv_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (ctl_i.latch) begin
        n_q      <= CW'(n_eff);
        s_q      <= start_node_i;
        t_q      <= target_node_i;
        u_q      <= '0;
        v_q      <= '0;
        r_q      <= '0;
        chk_q    <= 1'b0;
        pvalid_q <= '0;
      end
      if (ctl_i.init_step) begin
        v_q <= last_col ? '0 : v_q + NB'(1);
      end
      if (ctl_i.chk_begin) begin
        chk_q <= 1'b1;
        u_q   <= '0;
        v_q   <= '0;
      end
      // Advance column, then row, then round
      if (ctl_i.adv) begin
        if (!last_col) begin
          v_q <= v_q + NB'(1);
        end else begin
          v_q <= '0;
          if (!last_row) begin
            u_q <= u_q + NB'(1);
          end else begin
            u_q <= '0;
            r_q <= r_q + NB'(1);
          end
        end
      end
      if (do_relax) begin
        pvalid_q[v_q] <= 1'b1;
      end
      if (ctl_i.path_begin) begin
        pv_q  <= NB'(t_q);
        cnt_q <= '0;
      end
      if (ctl_i.path_emit && path_more) begin
        pv_q  <= pred_rd_q;
        cnt_q <= cnt_q + PCNT_W'(1);
      end
    end
  end

  // Row distance and relax arithmetic
  always_ff @(posedge clk_i) begin
    if (ctl_i.row_ld) begin
      du_q <= dist_rd_q;
    end
    if (ctl_i.edge_add) begin
      cand_q <= sum_sat;
      skip_q <= (w_rd_q == no_edge_w);
    end
    // A relaxed self loop changes the row distance for the rest of the row
    if (do_relax && (u_q == v_q)) begin
      du_q <= cand_q;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.path_emit || ctl_i.fail_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.path_emit) begin
      res_node_q  <= NODE_FIELD_W'(pv_q);
      res_found_q <= 1'b1;
      res_last_q  <= !path_more;
    end else if (ctl_i.fail_emit) begin
      res_node_q  <= '0;
      res_found_q <= 1'b0;
      res_last_q  <= 1'b1;
    end
  end

  assign result_valid_o = res_valid_q;
  assign path_node_o    = res_node_q;
  assign found_o        = res_found_q;
  assign last_o         = res_last_q;

  // Status to the controller
  always_comb begin
    status_o            = '0;
    status_o.bad_ends   = (XW'(s_q) >= XW'(n_q)) || (XW'(t_q) >= XW'(n_q));
    status_o.last_col   = last_col;
    status_o.last_row   = last_row;
    status_o.last_round = ((CW'(r_q) + CW'(2)) == n_q);
    status_o.no_rounds  = (n_q == CW'(1));
    status_o.chk_mode   = chk_q;
    status_o.relax      = relax;
    status_o.t_inf      = (dist_rd_q == INF_DIST);
    status_o.path_more  = path_more;
  end

endmodule

/* design/bellman_ford_shortest_path.sv */
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// Single source shortest path over a dense signed weight matrix with
// negative cycle detection; emits the path from target back to start.
// ----------------------------------------------------------------------------
// Load transactions are accepted back to back while idle; busy stays low.
// A run steps through initialization, the relaxation rounds and the check
// pass, each edge step reading, adding and comparing in turn, then walks
// the path, reading and emitting each result with one strobe each.
// A run with a bad start or target node emits a failure result.
// Reset restores control and configuration; distances are rewritten per run.
module bellman_ford_shortest_path #(
  parameter int unsigned NODES       = bfsp_pkg::NODES_DEF,
  parameter int unsigned WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]   from_node_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]   to_node_i,
  input  logic signed [bfsp_pkg::DATA_W-1:0]  weight_i,
  input  logic [bfsp_pkg::NODE_FIELD_W-1:0]   target_node_i,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bfsp_pkg::DATA_W-1:0]         cfg_data_i,
  // Results
  output logic                                result_valid_o,
  output logic [bfsp_pkg::NODE_FIELD_W-1:0]   path_node_o,
  output logic                                found_o,
  output logic                                last_o
);
  import bfsp_pkg::*;

  logic [COUNT_W-1:0]        node_count_q;
  logic [NODE_FIELD_W-1:0]   start_node_q;
  logic signed [DATA_W-1:0]  no_edge_q;
  bfsp_cmd_t                 ctl;
  bfsp_status_t              status;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      start_node_q <= START_NODE_RST;
      no_edge_q    <= NO_EDGE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NODE_COUNT: node_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_START_NODE: start_node_q <= cfg_data_i[NODE_FIELD_W-1:0];
        CFG_NO_EDGE:    no_edge_q    <= signed'(cfg_data_i);
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Sequencer
  bfsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .status_i (status),
    .ctl_o    (ctl),
    .busy     (busy)
  );

  // Datapath
  bfsp_dpath #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .status_o       (status),
    .node_count_i   (node_count_q),
    .start_node_i   (start_node_q),
    .no_edge_i      (no_edge_q),
    .from_node_i    (from_node_i),
    .to_node_i      (to_node_i),
    .weight_i       (weight_i),
    .target_node_i  (target_node_i),
    .path_node_o    (path_node_o),
    .found_o        (found_o),
    .last_o         (last_o),
    .result_valid_o (result_valid_o)
  );

  // A run transaction always occupies the engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_RUN) |=> busy)
    else $error("run transaction did not raise busy");

  // A load transaction leaves the engine free for the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_LOAD) |=> !busy)
    else $error("load transaction raised busy");

  // A failure result is the only and final result of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !found_o |-> last_o && (path_node_o == '0))
    else $error("failure result not marked last or carries a node");

  // Nothing follows the final result directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result strobe right after final result");

endmodule
